// ===== rtl/core/ppr_pkg.sv =====
`timescale 1ns / 1ps

package ppr_pkg;

  localparam logic [2:0] MODE_INIT    = 3'd0;
  localparam logic [2:0] MODE_STARTUP = 3'd1;
  localparam logic [2:0] MODE_STANDBY = 3'd2;
  localparam logic [2:0] MODE_WRITING = 3'd3;
  localparam logic [2:0] MODE_READING = 3'd4;
  localparam logic [2:0] MODE_ERROR   = 3'd5;

  localparam logic [2:0] ACT_START    = 3'd0;
  localparam logic [2:0] ACT_DONE     = 3'd1;
  localparam logic [2:0] ACT_ERROR    = 3'd2;
  localparam logic [2:0] ACT_WRITE    = 3'd3;
  localparam logic [2:0] ACT_READ     = 3'd4;

  localparam logic [1:0] RSTAT_NONE   = 2'd0;
  localparam logic [1:0] RSTAT_OK     = 2'd1;
  localparam logic [1:0] RSTAT_FAIL   = 2'd2;

  localparam logic [6:0]  ADDR_BASE   = 7'h50;
  localparam logic [15:0] ALL_ONES    = 16'hFFFF;
  localparam logic [15:0] HALF_RANGE  = 16'h8000;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] footer_seq;
    logic [15:0] footer_check;
  } in_item_t;

  typedef struct packed {
    logic        issue_read;
    logic        issue_write;
    logic [6:0]  device_address;
    logic [15:0] new_seq;
    logic [15:0] new_seq_check;
    logic        ready_res;
    logic [1:0]  rd_status;
    logic        write_done;
    logic        fault;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic        target_page;
    logic        latest_valid;
    logic        latest_page;
    logic [15:0] seq0;
    logic [15:0] seq1;
    logic [15:0] chk0;
    logic [15:0] chk1;
    logic [15:0] pending_seq;
  } state_t;

endpackage

// ===== rtl/core/ping_pong_record_page_controller_top.sv =====
`timescale 1ns / 1ps

// Two-page record store controller. Takes one event item per clock while
// the input is not stalled, and returns exactly one result item per event, in
// order. An accepted item is held in the input register, is evaluated against
// the controller state and lands in the output register, from which its result
// shows on the output; throughput is one item per cycle unless stalled, with
// the state update done by the combinational step logic. The input stalls
// only while a result waits under a stalled output and the input register is
// also full.
module ping_pong_record_page_controller_top import ppr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  logic      in_valid_q;
  in_item_t  in_item_q;
  logic      out_valid_q;
  out_item_t out_item_q;
  state_t    st_q, st_d;
  out_item_t res;
  logic      advance;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;

  ppr_step u_step (
    .st_i   (st_q),
    .item_i (in_item_q),
    .st_o   (st_d),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      st_q        <= '0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        st_q        <= st_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o) begin
      in_item_q <= in_item_i;
    end
    if (advance) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ===== rtl/core/ppr_step.sv =====
`timescale 1ns / 1ps

module ppr_step import ppr_pkg::*; (
  input  state_t    st_i,
  input  in_item_t  item_i,
  output state_t    st_o,
  output out_item_t res_o
);

  logic        ok0;
  logic [15:0] diff;
  logic [15:0] base_seq;
  logic        wr_page;
  logic [15:0] wr_seq;

  // Footer validity uses the footers as they stand before this item.
  assign ok0      = (st_i.seq0 ^ st_i.chk0) == ALL_ONES;
  assign diff     = st_i.seq0 - item_i.footer_seq;
  assign base_seq = st_i.latest_page ? st_i.seq1 : st_i.seq0;
  assign wr_page  = st_i.latest_valid ? ~st_i.latest_page : 1'b0;
  assign wr_seq   = st_i.latest_valid ? base_seq + 16'd1 : 16'd0;

  always_comb begin
    logic v1;
    st_o  = st_i;
    res_o = '0;
    res_o.device_address = ADDR_BASE;
    // page 1 footer arrives with the item itself at the end of startup
    v1 = (item_i.footer_seq ^ item_i.footer_check) == ALL_ONES;
    unique case (item_i.action)
      ACT_START: begin
        if (st_i.mode == MODE_INIT) begin
          st_o.mode        = MODE_STARTUP;
          st_o.target_page = 1'b0;
          res_o.issue_read = 1'b1;
        end
      end
      ACT_DONE: begin
        if (st_i.mode == MODE_STARTUP) begin
          if (st_i.target_page) begin
            st_o.seq1 = item_i.footer_seq;
            st_o.chk1 = item_i.footer_check;
            if (ok0 && v1) begin
              st_o.latest_valid = 1'b1;
              st_o.latest_page  = (diff >= HALF_RANGE);
            end else begin
              st_o.latest_valid = ok0 | v1;
              st_o.latest_page  = v1 & ~ok0;
            end
            res_o.ready_res = 1'b1;
            st_o.mode       = MODE_STANDBY;
          end else begin
            st_o.seq0        = item_i.footer_seq;
            st_o.chk0        = item_i.footer_check;
            st_o.target_page = 1'b1;
            res_o.issue_read = 1'b1;
            res_o.device_address = ADDR_BASE | 7'd1;
          end
        end else if (st_i.mode == MODE_WRITING) begin
          if (st_i.target_page) begin
            st_o.seq1 = st_i.pending_seq;
            st_o.chk1 = ~st_i.pending_seq;
          end else begin
            st_o.seq0 = st_i.pending_seq;
            st_o.chk0 = ~st_i.pending_seq;
          end
          st_o.latest_valid = 1'b1;
          st_o.latest_page  = st_i.target_page;
          res_o.write_done  = 1'b1;
          st_o.mode         = MODE_STANDBY;
        end else if (st_i.mode == MODE_READING) begin
          res_o.rd_status = RSTAT_OK;
          st_o.mode       = MODE_STANDBY;
        end
      end
      ACT_ERROR: begin
        if (st_i.mode == MODE_STARTUP) begin
          st_o.latest_valid = 1'b0;
          st_o.latest_page  = 1'b0;
          res_o.fault       = 1'b1;
          res_o.ready_res   = 1'b1;
          st_o.mode         = MODE_STANDBY;
        end else if (st_i.mode == MODE_WRITING || st_i.mode == MODE_READING) begin
          res_o.fault = 1'b1;
          st_o.mode   = MODE_ERROR;
        end
      end
      ACT_WRITE: begin
        if (st_i.mode == MODE_STANDBY) begin
          st_o.target_page     = wr_page;
          st_o.pending_seq     = wr_seq;
          res_o.issue_write    = 1'b1;
          res_o.device_address = ADDR_BASE | {6'd0, wr_page};
          res_o.new_seq        = wr_seq;
          res_o.new_seq_check  = ~wr_seq;
          st_o.mode            = MODE_WRITING;
        end
      end
      ACT_READ: begin
        if (st_i.mode == MODE_STANDBY) begin
          if (!st_i.latest_valid) begin
            res_o.rd_status = RSTAT_FAIL;
          end else begin
            st_o.target_page     = st_i.latest_page;
            res_o.issue_read     = 1'b1;
            res_o.device_address = ADDR_BASE | {6'd0, st_i.latest_page};
            st_o.mode            = MODE_READING;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/core/ppr_checker.sv =====
`timescale 1ns / 1ps

module ppr_checker import ppr_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_item_o
);

  // a held result must not change under stall
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_item_o.issue_read && out_item_o.issue_write))
    else $error("read and write issued together");

  a_footer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.issue_write ?
      (out_item_o.new_seq_check == ~out_item_o.new_seq) :
      (out_item_o.new_seq == 16'd0 && out_item_o.new_seq_check == 16'd0)))
    else $error("bad footer on result");

  a_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.device_address[6:1] == ADDR_BASE[6:1]) &&
      (out_item_o.issue_read || out_item_o.issue_write ||
       !out_item_o.device_address[0]))
    else $error("bad device address");

  // a stall on the input side only arises from a blocked output
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with output free");

endmodule

bind ping_pong_record_page_controller_top ppr_checker u_ppr_checker (.*);
